@@ src/tmmh_pkg.sv @@
// Package: shared widths, constants, register codes and control structs of the moisture block.
package tmmh_pkg;

  // Burst length and field widths
  localparam int SAMPLES_PER_BURST = 8;
  localparam int ADC_W             = 12;
  localparam int PCT_W             = 7;
  localparam int CNT_W             = $clog2(SAMPLES_PER_BURST);
  localparam int SUM_W             = ADC_W + $clog2(SAMPLES_PER_BURST);
  localparam int FULL_SCALE_PCT    = 100;
  localparam int SCALE_W           = 7;
  localparam int NUM_W             = ADC_W + SCALE_W;
  localparam int DIV_W             = NUM_W;
  localparam int DVS_W             = ADC_W;
  localparam int DIV_CNT_W         = $clog2(DIV_W);

  // Trimmed mean by reciprocal multiply, exact for every sum below 2**SUM_W
  localparam int TRIM_DIV    = SAMPLES_PER_BURST - 2;
  localparam int RECIP_SHIFT = SUM_W + $clog2(TRIM_DIV);
  localparam int RECIP_W     = SUM_W + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [CNT_W-1:0]   LAST_COUNT = CNT_W'(SAMPLES_PER_BURST - 1);
  localparam logic [RECIP_W-1:0] TRIM_RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + TRIM_DIV - 1) / TRIM_DIV);
  localparam logic [SCALE_W-1:0] PCT_SCALE  = SCALE_W'(FULL_SCALE_PCT);
  localparam logic [ADC_W-1:0]   ADC_MAX    = '1;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam int REG_DATA_W = ADC_W;
  localparam logic [REG_IDX_W-1:0] REG_DRY    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOAKED = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_UPPER  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOWER  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic take;       // sample transfer this cycle
    logic load_mean;  // latch trimmed sum, clear burst
    logic map;        // clamp mean and scale to percent numerator
    logic load_pct;   // start percent division
    logic decide;     // hysteresis update and result load
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_sample;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

@@ src/tmmh_if.sv @@
// Interfaces: sample input channel and result output channel.
interface tmmh_in_if;
  logic                      valid;
  logic                      ready;
  logic [tmmh_pkg::ADC_W-1:0] sample;
  logic                      force_water;

  modport source(output valid, sample, force_water, input ready);
  modport sink(input valid, sample, force_water, output ready);
endinterface

interface tmmh_out_if;
  logic                      valid;
  logic                      ready;
  logic [tmmh_pkg::PCT_W-1:0] moisture_percent;
  logic                      pump_on;
  logic                      long_run;

  modport source(output valid, moisture_percent, pump_on, long_run, input ready);
  modport sink(input valid, moisture_percent, pump_on, long_run, output ready);
endinterface

@@ src/tmmh_div.sv @@
// Restoring divider: one quotient bit per cycle.
module tmmh_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tmmh_pkg::DIV_W-1:0]  dividend,
  input  logic [tmmh_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [tmmh_pkg::DIV_W-1:0]  quotient
);

  logic                           busy;
  logic [tmmh_pkg::DIV_CNT_W-1:0] cnt;
  logic [tmmh_pkg::DVS_W-1:0]     rem;
  logic [tmmh_pkg::DVS_W-1:0]     dvs;
  logic [tmmh_pkg::DIV_W-1:0]     quo;
  logic [tmmh_pkg::DVS_W:0]       trial;
  logic [tmmh_pkg::DVS_W:0]       diff;
  logic                           ge;

  // Trial subtract of the shifted remainder
  assign trial = {rem, quo[tmmh_pkg::DIV_W-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  // Control: busy flag, step count, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == tmmh_pkg::DIV_CNT_W'(tmmh_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[tmmh_pkg::DIV_W-2:0], ge};
      rem <= ge ? diff[tmmh_pkg::DVS_W-1:0] : trial[tmmh_pkg::DVS_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

@@ src/tmmh_datapath.sv @@
// Datapath: config registers, burst accumulator, mapping, hysteresis and result register.
module tmmh_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  tmmh_pkg::ctrl_cmd_t             cmd,
  output tmmh_pkg::dp_status_t            status,
  input  logic                            wr_en,
  input  logic [tmmh_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [tmmh_pkg::REG_DATA_W-1:0] wr_data,
  input  logic [tmmh_pkg::ADC_W-1:0]      sample,
  input  logic                            force_water,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [tmmh_pkg::PCT_W-1:0]      moisture_percent,
  output logic                            pump_on,
  output logic                            long_run
);

  logic [tmmh_pkg::ADC_W-1:0] dry_level;
  logic [tmmh_pkg::ADC_W-1:0] soaked_level;
  logic [tmmh_pkg::PCT_W-1:0] off_level_pct;
  logic [tmmh_pkg::PCT_W-1:0] on_level_pct;

  logic [tmmh_pkg::SUM_W-1:0] sample_sum;
  logic [tmmh_pkg::ADC_W-1:0] sample_min;
  logic [tmmh_pkg::ADC_W-1:0] sample_max;
  logic [tmmh_pkg::CNT_W-1:0] sample_count;
  logic                       pump_state;
  logic                       forced;

  logic [tmmh_pkg::SUM_W-1:0]  trimmed;
  logic [tmmh_pkg::SUM_W-1:0]  trimmed_q;
  logic [tmmh_pkg::PROD_W-1:0] mean_prod;
  logic [tmmh_pkg::ADC_W-1:0]  mean;
  logic [tmmh_pkg::ADC_W-1:0]  clamped;
  logic [tmmh_pkg::NUM_W-1:0]  numerator;
  logic                        no_span;
  logic [tmmh_pkg::PCT_W-1:0]  pct;
  logic                        pump_next;

  logic                       div_start;
  logic [tmmh_pkg::DIV_W-1:0] div_dividend;
  logic [tmmh_pkg::DVS_W-1:0] div_divisor;
  logic                       div_done;
  logic [tmmh_pkg::DIV_W-1:0] div_quotient;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dry_level     <= tmmh_pkg::ADC_MAX;
      soaked_level  <= '0;
      off_level_pct <= '0;
      on_level_pct  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        tmmh_pkg::REG_DRY:    dry_level     <= wr_data[tmmh_pkg::ADC_W-1:0];
        tmmh_pkg::REG_SOAKED: soaked_level  <= wr_data[tmmh_pkg::ADC_W-1:0];
        tmmh_pkg::REG_UPPER:  off_level_pct <= wr_data[tmmh_pkg::PCT_W-1:0];
        tmmh_pkg::REG_LOWER:  on_level_pct  <= wr_data[tmmh_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Burst accumulator: sum, min, max, count; cleared once the trimmed sum is latched
  always_ff @(posedge clk) begin
    if (rst || cmd.load_mean) begin
      sample_sum   <= '0;
      sample_min   <= tmmh_pkg::ADC_MAX;
      sample_max   <= '0;
      sample_count <= '0;
    end else if (cmd.take) begin
      sample_sum   <= sample_sum + tmmh_pkg::SUM_W'(sample);
      if (sample < sample_min) sample_min <= sample;
      if (sample > sample_max) sample_max <= sample;
      sample_count <= sample_count + 1'b1;
    end
  end

  // Force command only counts with the last sample of a burst
  always_ff @(posedge clk) begin
    if (cmd.take && status.last_sample) begin
      forced <= force_water;
    end
  end

  assign trimmed = sample_sum - tmmh_pkg::SUM_W'(sample_min) - tmmh_pkg::SUM_W'(sample_max);

  // Trimmed sum latched as the burst clears
  always_ff @(posedge clk) begin
    if (cmd.load_mean) begin
      trimmed_q <= trimmed;
    end
  end

  // Divide by burst-2 with a reciprocal multiply; the mean is registered from the latched sum
  assign mean_prod = trimmed_q * tmmh_pkg::TRIM_RECIP;
  always_ff @(posedge clk) begin
    mean <= mean_prod[tmmh_pkg::RECIP_SHIFT +: tmmh_pkg::ADC_W];
  end

  // Iterative divider: scaled span by dry-soaked
  assign div_start    = cmd.load_pct;
  assign div_dividend = numerator;
  assign div_divisor  = dry_level - soaked_level;

  tmmh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Clamp mean into [soaked, dry]
  always_comb begin
    clamped = mean;
    if (clamped <= soaked_level) clamped = soaked_level;
    if (clamped >= dry_level)    clamped = dry_level;
  end

  // Scaled distance from dry, registered after the multiply
  always_ff @(posedge clk) begin
    if (cmd.map) begin
      numerator <= (dry_level - clamped) * tmmh_pkg::PCT_SCALE;
      no_span   <= (dry_level <= soaked_level);
    end
  end

  // Percent and hysteresis decision
  assign pct = no_span ? '0 : div_quotient[tmmh_pkg::PCT_W-1:0];
  always_comb begin
    pump_next = pump_state;
    if (forced) begin
      pump_next = 1'b1;
    end else if (pct < on_level_pct) begin
      pump_next = 1'b1;
    end else if (pct >= off_level_pct) begin
      pump_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pump_state <= 1'b0;
    end else if (cmd.decide) begin
      pump_state <= pump_next;
    end
  end

  // Result register, frees the datapath while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.decide) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      moisture_percent <= pct;
      pump_on          <= pump_next;
      long_run         <= forced;
    end
  end

  // Status to the controller
  always_comb begin
    status.last_sample = (sample_count == tmmh_pkg::LAST_COUNT);
    status.div_done    = div_done;
    status.out_busy    = out_valid & ~out_ready;
  end

endmodule

@@ src/tmmh_ctrl.sv @@
// Controller: sequences accumulate, mean, mapping, percent division and decision.
module tmmh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tmmh_pkg::dp_status_t status,
  output tmmh_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_ACC       = 7'b0000001,
    ST_LOAD_MEAN = 7'b0000010,
    ST_MEAN      = 7'b0000100,
    ST_MAP       = 7'b0001000,
    ST_LOAD_PCT  = 7'b0010000,
    ST_DIV_PCT   = 7'b0100000,
    ST_DECIDE    = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   take;

  assign in_ready = (state == ST_ACC);
  assign take     = in_ready & in_valid;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_ACC:       if (take && status.last_sample) state_next = ST_LOAD_MEAN;
      ST_LOAD_MEAN: state_next = ST_MEAN;
      ST_MEAN:      state_next = ST_MAP;
      ST_MAP:       state_next = ST_LOAD_PCT;
      ST_LOAD_PCT:  state_next = ST_DIV_PCT;
      ST_DIV_PCT:   if (status.div_done) state_next = ST_DECIDE;
      ST_DECIDE:    if (!status.out_busy) state_next = ST_ACC;
      default:      state_next = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  // Commands
  always_comb begin
    cmd.take      = take;
    cmd.load_mean = (state == ST_LOAD_MEAN);
    cmd.map       = (state == ST_MAP);
    cmd.load_pct  = (state == ST_LOAD_PCT);
    cmd.decide    = (state == ST_DECIDE) && !status.out_busy;
  end

endmodule

@@ src/trimmed_mean_moisture_hysteresis_top.sv @@
// Top level: trimmed-mean soil moisture with hysteresis pump decision.
// Samples arrive on the samples channel at one transfer per cycle; after the
// last of SAMPLES_PER_BURST samples the block drops the burst minimum and
// maximum, divides the rest by SAMPLES_PER_BURST-2, clamps the mean between
// soaked_level and dry_level, maps it to 0..100 percent (dry is 0, 0 when dry
// is not above soaked) and updates the pump flag: on below the turn-on level,
// off at or above the turn-off level, forced on with long_run when force_water
// comes with the last sample. The mean uses a reciprocal multiply, and the
// percent division runs on a one-bit-per-cycle divider; samples are not taken
// during that post-processing. The result sits in an output register, so the
// next burst is accepted while a result waits to be taken. Config registers
// are written through wr_en/wr_index/wr_data; the user must write them only
// while idle, as the block itself does not enforce it.
module trimmed_mean_moisture_hysteresis_top (
  input  logic                            clk,
  input  logic                            rst,
  tmmh_in_if.sink                         samples,
  tmmh_out_if.source                      result,
  input  logic                            wr_en,
  input  logic [tmmh_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [tmmh_pkg::REG_DATA_W-1:0] wr_data
);

  tmmh_pkg::ctrl_cmd_t  cmd;
  tmmh_pkg::dp_status_t status;

  tmmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tmmh_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .sample           (samples.sample),
    .force_water      (samples.force_water),
    .out_ready        (result.ready),
    .out_valid        (result.valid),
    .moisture_percent (result.moisture_percent),
    .pump_on          (result.pump_on),
    .long_run         (result.long_run)
  );

endmodule

@@ src/tmmh_checker.sv @@
// Checker: port-level assertions for the moisture block, bound to the top level.
module tmmh_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tmmh_pkg::PCT_W-1:0] moisture_percent,
  input logic                       pump_on,
  input logic                       long_run
);

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(moisture_percent) && $stable(pump_on) && $stable(long_run))
    else $error("result payload changed while stalled");

  // Percent never exceeds full scale
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> moisture_percent <= tmmh_pkg::PCT_W'(tmmh_pkg::FULL_SCALE_PCT))
    else $error("moisture percent above 100");

  // A forced long run always drives the pump
  a_long_pump: assert property (@(posedge clk) disable iff (rst)
    out_valid && long_run |-> pump_on)
    else $error("long run without pump on");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind trimmed_mean_moisture_hysteresis_top tmmh_checker u_tmmh_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .moisture_percent (result.moisture_percent),
  .pump_on          (result.pump_on),
  .long_run         (result.long_run)
);

@@ verif/tmmh_checker.sv @@
// Checker: watches the sample, result and register ports, predicts each burst result and compares.
`timescale 1ns / 1ps

module tmmh_scoreboard (
  input  logic                            clk,
  input  logic                            rst,
  tmmh_in_if                              samples,
  tmmh_out_if                             result,
  input  logic                            wr_en,
  input  logic [tmmh_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [tmmh_pkg::REG_DATA_W-1:0] wr_data,
  output int                              mismatch_count,
  output int                              pending_results
);

  typedef struct packed {
    logic [tmmh_pkg::PCT_W-1:0] moisture_percent;
    logic                       pump_on;
    logic                       long_run;
  } moisture_result_t;

  localparam int MAX_REPORTS = 10;

  moisture_result_t burst_results[$];

  // Shadow copy of the register file
  logic [tmmh_pkg::ADC_W-1:0] dry_cfg;
  logic [tmmh_pkg::ADC_W-1:0] soaked_cfg;
  logic [tmmh_pkg::PCT_W-1:0] upper_cfg;
  logic [tmmh_pkg::PCT_W-1:0] lower_cfg;

  // Burst statistics and hysteresis flag
  logic [tmmh_pkg::SUM_W-1:0] burst_sum;
  logic [tmmh_pkg::ADC_W-1:0] burst_min;
  logic [tmmh_pkg::ADC_W-1:0] burst_max;
  int                         burst_count;
  logic                       pump_flag;
  int                         fail_tally;

  function automatic logic [tmmh_pkg::PCT_W-1:0] moisture_from_mean(int mean);
    int dry;
    int soaked;
    int v;
    dry = int'(dry_cfg);
    soaked = int'(soaked_cfg);
    v = mean;
    if (dry <= soaked) return '0;
    if (v <= soaked) v = soaked;
    if (v >= dry) v = dry;
    return tmmh_pkg::PCT_W'(((dry - v) * tmmh_pkg::FULL_SCALE_PCT) / (dry - soaked));
  endfunction

  task automatic clear_burst();
    burst_sum = '0;
    burst_min = tmmh_pkg::ADC_MAX;
    burst_max = '0;
    burst_count = 0;
  endtask

  // Accumulate one sample; the last one of a burst yields a result
  task automatic accumulate_sample(logic [tmmh_pkg::ADC_W-1:0] s, logic forced);
    int mean;
    moisture_result_t r;
    burst_sum = burst_sum + tmmh_pkg::SUM_W'(s);
    if (s < burst_min) burst_min = s;
    if (s > burst_max) burst_max = s;
    burst_count++;
    if (burst_count < tmmh_pkg::SAMPLES_PER_BURST) return;
    mean = (int'(burst_sum) - int'(burst_min) - int'(burst_max))
           / (tmmh_pkg::SAMPLES_PER_BURST - 2);
    r.moisture_percent = moisture_from_mean(mean);
    if (forced) begin
      pump_flag = 1'b1;
      r.long_run = 1'b1;
    end else begin
      // lower test first, so crossed thresholds turn the pump on
      if (r.moisture_percent < lower_cfg) pump_flag = 1'b1;
      else if (r.moisture_percent >= upper_cfg) pump_flag = 1'b0;
      r.long_run = 1'b0;
    end
    r.pump_on = pump_flag;
    burst_results.push_back(r);
    clear_burst();
  endtask

  task automatic check_result();
    moisture_result_t got;
    moisture_result_t want;
    got.moisture_percent = result.moisture_percent;
    got.pump_on = result.pump_on;
    got.long_run = result.long_run;
    if (burst_results.size() == 0) begin
      fail_tally++;
      if (fail_tally <= MAX_REPORTS)
        $display("%0t: unexpected result pct=%0d pump=%0b long=%0b", $realtime,
                 got.moisture_percent, got.pump_on, got.long_run);
      return;
    end
    want = burst_results.pop_front();
    if (got !== want) begin
      fail_tally++;
      if (fail_tally <= MAX_REPORTS)
        $display({"%0t: result mismatch exp pct=%0d pump=%0b long=%0b,",
                  " got pct=%0d pump=%0b long=%0b"},
                 $realtime, want.moisture_percent, want.pump_on, want.long_run,
                 got.moisture_percent, got.pump_on, got.long_run);
    end
  endtask

  // Register writes, sample transfers and result transfers, all at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      dry_cfg = tmmh_pkg::ADC_MAX;
      soaked_cfg = '0;
      upper_cfg = '0;
      lower_cfg = '0;
      pump_flag = 1'b0;
      fail_tally = 0;
      clear_burst();
      burst_results.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          tmmh_pkg::REG_DRY:    dry_cfg = wr_data[tmmh_pkg::ADC_W-1:0];
          tmmh_pkg::REG_SOAKED: soaked_cfg = wr_data[tmmh_pkg::ADC_W-1:0];
          tmmh_pkg::REG_UPPER:  upper_cfg = wr_data[tmmh_pkg::PCT_W-1:0];
          tmmh_pkg::REG_LOWER:  lower_cfg = wr_data[tmmh_pkg::PCT_W-1:0];
          default: ;
        endcase
      end
      if (samples.valid === 1'b1 && samples.ready === 1'b1)
        accumulate_sample(samples.sample, samples.force_water);
      if (result.valid === 1'b1 && result.ready === 1'b1)
        check_result();
    end
    mismatch_count <= fail_tally;
    pending_results <= burst_results.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top: clock, reset, register setup, sample bursts, result backpressure and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int BURSTS_PER_SET = 10;
  localparam int NUM_SETS       = 12;
  localparam int SETTLE_CYCLES  = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                            wr_en;
  logic [tmmh_pkg::REG_IDX_W-1:0]  wr_index;
  logic [tmmh_pkg::REG_DATA_W-1:0] wr_data;

  int  mismatch_count;
  int  pending_results;
  int  cycle_count = 0;
  int  ready_left;
  bit  calm_phase;
  int  win_lo;
  int  win_hi;

  tmmh_in_if  samples_if();
  tmmh_out_if result_if();

  always #2 clk = ~clk;

  trimmed_mean_moisture_hysteresis_top dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_if),
    .result   (result_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  tmmh_scoreboard moisture_check (
    .clk             (clk),
    .rst             (rst),
    .samples         (samples_if),
    .result          (result_if),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result backpressure: bursts of ready, short stalls, now and then a long one
  initial begin
    result_if.ready = 1'b0;
    ready_left = 0;
    forever begin
      @(negedge clk);
      if (ready_left == 0) begin
        if (calm_phase || $urandom_range(0, 99) < 70) begin
          result_if.ready = 1'b1;
          ready_left = $urandom_range(1, 20);
        end else begin
          result_if.ready = 1'b0;
          ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 4);
        end
      end
      ready_left--;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_phase || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [tmmh_pkg::ADC_W-1:0] pick_sample(int center, int spread);
    int v;
    v = center - spread + $urandom_range(0, 2 * spread);
    if (v < 0) v = 0;
    if (v > int'(tmmh_pkg::ADC_MAX)) v = int'(tmmh_pkg::ADC_MAX);
    return tmmh_pkg::ADC_W'(v);
  endfunction

  // One sample transfer; called and returns at a falling edge
  task automatic send_sample(logic [tmmh_pkg::ADC_W-1:0] s, logic forced);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      samples_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_if.valid = 1'b1;
    samples_if.sample = s;
    samples_if.force_water = forced;
    do @(posedge clk); while (samples_if.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [tmmh_pkg::REG_IDX_W-1:0] idx,
                           logic [tmmh_pkg::REG_DATA_W-1:0] val);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  // Wait until all results are back and the divider has finished
  task automatic wait_idle();
    samples_if.valid = 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_settings(int dry, int soaked, int upper, int lower);
    write_reg(tmmh_pkg::REG_DRY, tmmh_pkg::REG_DATA_W'(dry));
    write_reg(tmmh_pkg::REG_SOAKED, tmmh_pkg::REG_DATA_W'(soaked));
    write_reg(tmmh_pkg::REG_UPPER, tmmh_pkg::REG_DATA_W'(upper));
    write_reg(tmmh_pkg::REG_LOWER, tmmh_pkg::REG_DATA_W'(lower));
    // window where bursts land, so the mapping and thresholds get exercised
    if (dry > soaked) begin
      win_lo = soaked;
      win_hi = dry;
    end else begin
      win_lo = 0;
      win_hi = int'(tmmh_pkg::ADC_MAX);
    end
  endtask

  // Register settings per phase: fixed corners first, then random ones
  task automatic configure_set(int set_idx);
    int d;
    int s;
    case (set_idx)
      1: apply_settings(3000, 1000, 60, 30);
      2: apply_settings(4095, 0, 100, 0);
      3: apply_settings(0, 4095, 50, 50);      // dry below soaked
      4: apply_settings(2000, 2000, 10, 127);  // dry equals soaked
      5: apply_settings(2048, 2047, 127, 127); // one-count span
      6: apply_settings(3500, 500, 20, 80);    // crossed thresholds
      7: apply_settings(4095, 4094, 0, 100);
      default: begin
        d = $urandom_range(0, 4095);
        s = $urandom_range(0, 4095);
        if ($urandom_range(0, 4) != 0 && d < s) begin
          d = d ^ s;
          s = d ^ s;
          d = d ^ s;
        end
        // thresholds sometimes above 100, upper data bits set to check masking
        apply_settings(d, s,
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 100),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 100));
      end
    endcase
  endtask

  task automatic send_random_burst();
    int mode;
    int center;
    int spread;
    logic forced_last;
    logic [tmmh_pkg::ADC_W-1:0] s;
    mode = $urandom_range(0, 9);
    center = $urandom_range(win_lo, win_hi);
    spread = $urandom_range(0, 150);
    forced_last = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < tmmh_pkg::SAMPLES_PER_BURST; i++) begin
      case (mode)
        0, 1: s = tmmh_pkg::ADC_W'($urandom_range(0, 4095));
        2: begin
          case ($urandom_range(0, 2))
            0: s = '0;
            1: s = tmmh_pkg::ADC_MAX;
            default: s = tmmh_pkg::ADC_W'($urandom_range(0, 4095));
          endcase
        end
        default: s = pick_sample(center, spread);
      endcase
      // force_water on earlier samples is ignored by the block
      if (i == tmmh_pkg::SAMPLES_PER_BURST - 1) send_sample(s, forced_last);
      else send_sample(s, ($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    wr_en = 1'b0;
    wr_index = tmmh_pkg::REG_DRY;
    wr_data = '0;
    samples_if.valid = 1'b0;
    samples_if.sample = '0;
    samples_if.force_water = 1'b0;
    calm_phase = 1'b0;
    win_lo = 0;
    win_hi = int'(tmmh_pkg::ADC_MAX);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed bursts at reset settings: all soaked, all dry forced, extremes mixed
    for (int i = 0; i < tmmh_pkg::SAMPLES_PER_BURST; i++) send_sample('0, 1'b0);
    for (int i = 0; i < tmmh_pkg::SAMPLES_PER_BURST; i++)
      send_sample(tmmh_pkg::ADC_MAX, (i == tmmh_pkg::SAMPLES_PER_BURST - 1));
    for (int i = 0; i < tmmh_pkg::SAMPLES_PER_BURST; i++)
      send_sample((i % 2 == 0) ? tmmh_pkg::ADC_MAX : '0,
                  (i != tmmh_pkg::SAMPLES_PER_BURST - 1));

    for (int set_idx = 0; set_idx < NUM_SETS; set_idx++) begin
      if (set_idx != 0) begin
        wait_idle();
        configure_set(set_idx);
      end
      calm_phase = (set_idx % 4 == 1);
      for (int b = (set_idx == 0) ? 3 : 0; b < BURSTS_PER_SET; b++) send_random_burst();
    end
    samples_if.valid = 1'b0;
    calm_phase = 1'b0;

    // Drain and let stray results show up
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
